// ----- src/i86dec_pkg.sv -----
// ----------------------------------------------------------------------------
// i86dec_pkg - shared types, codes and decode functions
// Opcode classification, phase sequencing and result assembly for the
// byte-serial 8086 subset decoder.
// ----------------------------------------------------------------------------
package i86dec_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] phase_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  form;
    logic [4:0]  jump_kind;
    logic        wide;
    logic        to_reg;
    logic [1:0]  mode;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
  } result_t;

  // instruction classes
  localparam kind_t K_INVALID = 3'd0;
  localparam kind_t K_JUMP    = 3'd1;
  localparam kind_t K_ALU_RM  = 3'd2;
  localparam kind_t K_ALU_ACC = 3'd3;
  localparam kind_t K_ALU_IMM = 3'd4;
  localparam kind_t K_MOV_RM  = 3'd5;
  localparam kind_t K_MOV_IMM = 3'd6;

  // decode phases: which byte is expected next
  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_MODRM   = 3'd1;
  localparam phase_t PH_DISP_LO = 3'd2;
  localparam phase_t PH_DISP_HI = 3'd3;
  localparam phase_t PH_IMM_LO  = 3'd4;
  localparam phase_t PH_IMM_HI  = 3'd5;

  // result operation codes
  localparam logic [2:0] OP_MOV     = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_SUB     = 3'd2;
  localparam logic [2:0] OP_CMP     = 3'd3;
  localparam logic [2:0] OP_JUMP    = 3'd4;
  localparam logic [2:0] OP_INVALID = 3'd5;

  // result form codes
  localparam logic [2:0] FORM_RM_REG = 3'd0;
  localparam logic [2:0] FORM_IMM_RM = 3'd1;
  localparam logic [2:0] FORM_IMM_AC = 3'd2;
  localparam logic [2:0] FORM_IMM_RG = 3'd3;
  localparam logic [2:0] FORM_JUMP   = 3'd4;

  // ALU selector in opcode bits 5:3 or in the reg field
  localparam logic [2:0] SEL_ADD = 3'b000;
  localparam logic [2:0] SEL_SUB = 3'b101;
  localparam logic [2:0] SEL_CMP = 3'b111;

  localparam logic [1:0] MOD_MEM   = 2'b00;
  localparam logic [1:0] MOD_D8    = 2'b01;
  localparam logic [1:0] MOD_D16   = 2'b10;
  localparam logic [1:0] MOD_REG   = 2'b11;
  localparam logic [2:0] RM_DIRECT = 3'b110;

  localparam int JUMP_COUNT = 20;
  localparam logic [7:0] JUMP_TABLE [JUMP_COUNT] = '{
    8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78, 8'h75, 8'h7D,
    8'h7F, 8'h73, 8'h77, 8'h7B, 8'h71, 8'h79, 8'hE2, 8'hE1, 8'hE0, 8'hE3
  };

  // {hit, index} of a jump/loop opcode
  function automatic logic [5:0] jump_lookup(logic [7:0] opc);
    logic       hit;
    logic [4:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < JUMP_COUNT; i++) begin
      if (!hit && opc == JUMP_TABLE[i]) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
    return {hit, idx};
  endfunction

  function automatic logic alu_ok(logic [2:0] sel);
    return sel == SEL_ADD || sel == SEL_SUB || sel == SEL_CMP;
  endfunction

  function automatic logic [2:0] alu_op(logic [2:0] sel);
    logic [2:0] op;
    unique case (sel)
      SEL_ADD: op = OP_ADD;
      SEL_SUB: op = OP_SUB;
      SEL_CMP: op = OP_CMP;
      default: op = OP_MOV;
    endcase
    return op;
  endfunction

  function automatic kind_t classify(logic [7:0] opc);
    logic [5:0] jl;
    kind_t      k;
    jl = jump_lookup(opc);
    if (jl[5])                             k = K_JUMP;
    else if ((opc & 8'hC4) == 8'h00)       k = alu_ok(opc[5:3]) ? K_ALU_RM : K_INVALID;
    else if ((opc & 8'hC6) == 8'h04)       k = alu_ok(opc[5:3]) ? K_ALU_ACC : K_INVALID;
    else if (opc[7:2] == 6'b100000)        k = K_ALU_IMM;
    else if (opc[7:2] == 6'b100010)        k = K_MOV_RM;
    else if (opc[7:4] == 4'hB)             k = K_MOV_IMM;
    else                                   k = K_INVALID;
    return k;
  endfunction

  function automatic logic has_modrm(kind_t k);
    return k == K_ALU_RM || k == K_ALU_IMM || k == K_MOV_RM;
  endfunction

  function automatic logic [1:0] disp_bytes(kind_t k, logic [7:0] modrm);
    logic [1:0] n;
    if (k == K_JUMP) n = 2'd1;
    else if (!has_modrm(k)) n = 2'd0;
    else begin
      unique case (modrm[7:6])
        MOD_MEM: n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
        MOD_D8:  n = 2'd1;
        MOD_D16: n = 2'd2;
        default: n = 2'd0;
      endcase
    end
    return n;
  endfunction

  function automatic logic [1:0] imm_bytes(kind_t k, logic [7:0] opc);
    logic [1:0] n;
    unique case (k)
      K_ALU_IMM: n = (opc[1:0] == 2'b01) ? 2'd2 : 2'd1;
      K_ALU_ACC: n = opc[0] ? 2'd2 : 2'd1;
      K_MOV_IMM: n = opc[3] ? 2'd2 : 2'd1;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

  // first needed phase after ph, PH_IDLE when the instruction is complete
  function automatic phase_t next_phase(phase_t ph, kind_t k, logic [7:0] modrm,
                                        logic [7:0] opc);
    logic [1:0] nd;
    logic [1:0] ni;
    phase_t     nxt;
    nd  = disp_bytes(k, modrm);
    ni  = imm_bytes(k, opc);
    nxt = PH_IDLE;
    if (ni == 2'd2 && ph < PH_IMM_HI)    nxt = PH_IMM_HI;
    if (ni != 2'd0 && ph < PH_IMM_LO)    nxt = PH_IMM_LO;
    if (nd == 2'd2 && ph < PH_DISP_HI)   nxt = PH_DISP_HI;
    if (nd != 2'd0 && ph < PH_DISP_LO)   nxt = PH_DISP_LO;
    if (has_modrm(k) && ph < PH_MODRM)   nxt = PH_MODRM;
    return nxt;
  endfunction

  function automatic result_t invalid_result(logic [2:0] len);
    result_t r;
    r           = '0;
    r.operation = OP_INVALID;
    r.length    = len;
    return r;
  endfunction

  function automatic result_t build_result(kind_t k, logic [7:0] opc, logic [7:0] modrm,
                                           logic [15:0] disp, logic [15:0] imm,
                                           logic [2:0] len);
    result_t    r;
    logic [5:0] jl;
    r        = '0;
    r.length = len;
    jl       = jump_lookup(opc);
    unique case (k)
      K_JUMP: begin
        r.operation    = OP_JUMP;
        r.form         = FORM_JUMP;
        r.jump_kind    = jl[4:0];
        r.displacement = {{8{disp[7]}}, disp[7:0]};
      end
      K_ALU_RM, K_MOV_RM: begin
        r.operation    = (k == K_MOV_RM) ? OP_MOV : alu_op(opc[5:3]);
        r.form         = FORM_RM_REG;
        r.wide         = opc[0];
        r.to_reg       = opc[1];
        r.mode         = modrm[7:6];
        r.reg_field    = modrm[5:3];
        r.rm_field     = modrm[2:0];
        r.displacement = disp;
      end
      K_ALU_IMM: begin
        r.operation    = alu_op(modrm[5:3]);
        r.form         = FORM_IMM_RM;
        r.wide         = opc[0];
        r.mode         = modrm[7:6];
        r.rm_field     = modrm[2:0];
        r.displacement = disp;
        // s bit: one byte, sign-extended
        r.immediate    = opc[1] ? {{8{imm[7]}}, imm[7:0]} : imm;
      end
      K_ALU_ACC: begin
        r.operation = alu_op(opc[5:3]);
        r.form      = FORM_IMM_AC;
        r.wide      = opc[0];
        r.to_reg    = 1'b1;
        r.mode      = MOD_REG;
        r.immediate = imm;
      end
      default: begin
        r.operation = OP_MOV;
        r.form      = FORM_IMM_RG;
        r.wide      = opc[3];
        r.to_reg    = 1'b1;
        r.mode      = MOD_REG;
        r.reg_field = opc[2:0];
        r.immediate = imm;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- src/i86dec_if.sv -----
// ----------------------------------------------------------------------------
// i86dec_if - channel interfaces
// Valid/ready channels for code bytes in and decoded instructions out.
// ----------------------------------------------------------------------------
interface i86dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface i86dec_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  form;
  logic [4:0]  jump_kind;
  logic        wide;
  logic        to_reg;
  logic [1:0]  mode;
  logic [2:0]  reg_field;
  logic [2:0]  rm_field;
  logic [15:0] displacement;
  logic [15:0] immediate;
  logic [2:0]  length;

  modport source (output valid, output operation, output form, output jump_kind,
                  output wide, output to_reg, output mode, output reg_field,
                  output rm_field, output displacement, output immediate,
                  output length, input ready);
  modport sink   (input valid, input operation, input form, input jump_kind,
                  input wide, input to_reg, input mode, input reg_field,
                  input rm_field, input displacement, input immediate,
                  input length, output ready);
endinterface

// ----- src/i86dec_core.sv -----
// ----------------------------------------------------------------------------
// i86dec_core - instruction byte collector
// Holds the decode phase and the opcode, mod-reg-rm, displacement and
// immediate latches; flags the word on which an instruction completes.
// ----------------------------------------------------------------------------
module i86dec_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          code_byte,
  output logic                done,
  output i86dec_pkg::result_t result
);
  import i86dec_pkg::*;

  phase_t      phase_r,  phase_nxt;
  kind_t       kind_r,   kind_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  modrm_r,  modrm_nxt;
  logic [15:0] disp_r,   disp_nxt;
  logic [15:0] imm_r,    imm_nxt;
  logic [2:0]  count_r,  count_nxt;
  phase_t      cur_ph;
  phase_t      nph;
  logic        bad;

  always_comb begin
    kind_nxt   = kind_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    imm_nxt    = imm_r;
    count_nxt  = count_r + 3'd1;
    cur_ph     = phase_r;
    bad        = 1'b0;
    unique case (phase_r)
      PH_MODRM: begin
        modrm_nxt = code_byte;
        bad       = kind_r == K_ALU_IMM && !alu_ok(code_byte[5:3]);
      end
      PH_DISP_LO: disp_nxt = {8'h00, code_byte};
      PH_DISP_HI: disp_nxt = {code_byte, disp_r[7:0]};
      PH_IMM_LO:  imm_nxt  = {8'h00, code_byte};
      PH_IMM_HI:  imm_nxt  = {code_byte, imm_r[7:0]};
      default: begin
        // opcode byte; unused phase codes land here too
        opcode_nxt = code_byte;
        kind_nxt   = classify(code_byte);
        modrm_nxt  = '0;
        disp_nxt   = '0;
        imm_nxt    = '0;
        count_nxt  = 3'd1;
        cur_ph     = PH_IDLE;
        bad        = kind_nxt == K_INVALID;
      end
    endcase

    nph = next_phase(cur_ph, kind_nxt, modrm_nxt, opcode_nxt);
    if (bad) begin
      phase_nxt = PH_IDLE;
      done      = 1'b1;
      result    = invalid_result(count_nxt);
    end else begin
      phase_nxt = nph;
      done      = nph == PH_IDLE;
      result    = build_result(kind_nxt, opcode_nxt, modrm_nxt, disp_nxt, imm_nxt,
                               count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  // latches are rewritten on every opcode byte
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r   <= kind_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      disp_r   <= disp_nxt;
      imm_r    <= imm_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/i8086_subset_instruction_decoder_top.sv -----
// ----------------------------------------------------------------------------
// i8086_subset_instruction_decoder_top - byte-serial 8086 subset decoder
// Decodes mov, add/sub/cmp and short jump/loop instructions from a stream
// of code bytes into one decoded word per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one instruction-stream byte per word (valid/ready).
//   out_ch : one decoded instruction word, issued on the word that carries
//            the instruction's last byte; bytes that do not end an
//            instruction produce nothing on out_ch.
//   Throughput: one byte per cycle while the output is not stalled. The decode
//   phase and latches update in the same cycle the byte is taken, so a new
//   byte can follow at once. The decoded word appears in the cycle after its
//   last byte is taken, from a single output register.
//   Unknown opcodes, and a group-80 byte with an unsupported reg field,
//   give an invalid word and restart decode at the next byte.
//   Reset puts the decoder back to expecting an opcode byte and empties
//   the output register.
//   Stall: while out_ch holds a word, in_ch.ready stays high only if the
//   held word is being taken that same cycle.
// ----------------------------------------------------------------------------
module i8086_subset_instruction_decoder_top (
  input  logic   clk,
  input  logic   rst_n,
  i86dec_in_if.sink    in_ch,
  i86dec_out_if.source out_ch
);
  import i86dec_pkg::*;

  logic    take;
  logic    done;
  result_t result;
  result_t res_r;
  logic    out_valid_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  i86dec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .code_byte (in_ch.code_byte),
    .done      (done),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && done) begin
      res_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.operation    = res_r.operation;
  assign out_ch.form         = res_r.form;
  assign out_ch.jump_kind    = res_r.jump_kind;
  assign out_ch.wide         = res_r.wide;
  assign out_ch.to_reg       = res_r.to_reg;
  assign out_ch.mode         = res_r.mode;
  assign out_ch.reg_field    = res_r.reg_field;
  assign out_ch.rm_field     = res_r.rm_field;
  assign out_ch.displacement = res_r.displacement;
  assign out_ch.immediate    = res_r.immediate;
  assign out_ch.length       = res_r.length;

endmodule

// ----- verif/i86dec_decode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i86dec_decode_checker - decoded-instruction scoreboard
// Watches the code-byte and decoded-word channels, predicts each decoded
// word from the accepted bytes and compares it field by field.
// ----------------------------------------------------------------------------
module i86dec_decode_checker (
  input  logic  clk,
  input  logic  rst_n,
  i86dec_in_if  in_ch,
  i86dec_out_if out_ch,
  output int    fail_count,
  output int    pending
);
  import i86dec_pkg::*;

  typedef enum logic [2:0] {
    WAIT_OPC, WAIT_MRM, WAIT_DLO, WAIT_DHI, WAIT_ILO, WAIT_IHI
  } byte_slot_e;

  typedef enum logic [2:0] {
    IC_BAD, IC_JCC, IC_ALU_RM, IC_ALU_ACC, IC_ALU_IMM, IC_MOV_RM, IC_MOV_IMM
  } instr_class_e;

  // je jl jle jb jbe jp jo js jne jnl jnle jnb jnbe jnp jno jns loop loopz loopnz jcxz
  localparam logic [7:0] JCC_OPCODES [20] = '{
    8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78, 8'h75, 8'h7D,
    8'h7F, 8'h73, 8'h77, 8'h7B, 8'h71, 8'h79, 8'hE2, 8'hE1, 8'hE0, 8'hE3
  };

  byte_slot_e  slot_q = WAIT_OPC;
  logic [7:0]  opc_q  = '0;
  logic [7:0]  mrm_q  = '0;
  logic [15:0] disp_q = '0;
  logic [15:0] imm_q  = '0;
  logic [2:0]  cnt_q  = '0;
  result_t     decoded_q [$];
  int          n_fail    = 0;
  int          n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  function automatic int jcc_slot(logic [7:0] opc);
    for (int i = 0; i < 20; i++) begin
      if (JCC_OPCODES[i] == opc) return i;
    end
    return -1;
  endfunction

  // OP_INVALID marks a selector that is not add, sub or cmp
  function automatic logic [2:0] sel_op(logic [2:0] sel);
    case (sel)
      SEL_ADD: return OP_ADD;
      SEL_SUB: return OP_SUB;
      SEL_CMP: return OP_CMP;
      default: return OP_INVALID;
    endcase
  endfunction

  function automatic instr_class_e class_of(logic [7:0] opc);
    if (jcc_slot(opc) >= 0) return IC_JCC;
    if (opc[7:6] == 2'b00 && !opc[2])
      return (sel_op(opc[5:3]) != OP_INVALID) ? IC_ALU_RM : IC_BAD;
    if (opc[7:6] == 2'b00 && opc[2:1] == 2'b10)
      return (sel_op(opc[5:3]) != OP_INVALID) ? IC_ALU_ACC : IC_BAD;
    if (opc[7:2] == 6'b100000) return IC_ALU_IMM;
    if (opc[7:2] == 6'b100010) return IC_MOV_RM;
    if (opc[7:4] == 4'hB) return IC_MOV_IMM;
    return IC_BAD;
  endfunction

  // first byte slot after cur that this instruction still needs
  function automatic byte_slot_e next_slot(byte_slot_e cur, instr_class_e cls);
    logic       has_mrm;
    int         n_disp;
    int         n_imm;
    logic [5:0] need;
    has_mrm = cls inside {IC_ALU_RM, IC_ALU_IMM, IC_MOV_RM};
    n_disp  = 0;
    if (cls == IC_JCC) begin
      n_disp = 1;
    end else if (has_mrm) begin
      case (mrm_q[7:6])
        MOD_MEM: n_disp = (mrm_q[2:0] == RM_DIRECT) ? 2 : 0;
        MOD_D8:  n_disp = 1;
        MOD_D16: n_disp = 2;
        default: n_disp = 0;
      endcase
    end
    case (cls)
      IC_ALU_IMM: n_imm = (opc_q[1:0] == 2'b01) ? 2 : 1;
      IC_ALU_ACC: n_imm = opc_q[0] ? 2 : 1;
      IC_MOV_IMM: n_imm = opc_q[3] ? 2 : 1;
      default:    n_imm = 0;
    endcase
    need           = '0;
    need[WAIT_MRM] = has_mrm;
    need[WAIT_DLO] = n_disp >= 1;
    need[WAIT_DHI] = n_disp == 2;
    need[WAIT_ILO] = n_imm >= 1;
    need[WAIT_IHI] = n_imm == 2;
    for (int p = int'(cur) + 1; p <= int'(WAIT_IHI); p++) begin
      if (need[p]) return byte_slot_e'(p);
    end
    return WAIT_OPC;
  endfunction

  function automatic result_t invalid_word(logic [2:0] len);
    result_t r;
    r           = '0;
    r.operation = OP_INVALID;
    r.length    = len;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    byte_slot_e   cur;
    instr_class_e cls;
    result_t      r;
    cur = slot_q;
    if (cur == WAIT_OPC) begin
      opc_q  = b;
      mrm_q  = '0;
      disp_q = '0;
      imm_q  = '0;
      cnt_q  = 3'd1;
      cls    = class_of(b);
      if (cls == IC_BAD) begin
        decoded_q.push_back(invalid_word(cnt_q));
        return;
      end
    end else begin
      cls   = class_of(opc_q);
      cnt_q = cnt_q + 3'd1;
      case (cur)
        WAIT_MRM: begin
          mrm_q = b;
          // group 80..83 only knows add, sub and cmp in the reg bits
          if (cls == IC_ALU_IMM && sel_op(b[5:3]) == OP_INVALID) begin
            slot_q = WAIT_OPC;
            decoded_q.push_back(invalid_word(cnt_q));
            return;
          end
        end
        WAIT_DLO: disp_q = {8'h00, b};
        WAIT_DHI: disp_q[15:8] = b;
        WAIT_ILO: imm_q = {8'h00, b};
        default:  imm_q[15:8] = b;
      endcase
    end

    slot_q = next_slot(cur, cls);
    if (slot_q != WAIT_OPC) return;

    r        = '0;
    r.length = cnt_q;
    case (cls)
      IC_JCC: begin
        r.operation    = OP_JUMP;
        r.form         = FORM_JUMP;
        r.jump_kind    = 5'(jcc_slot(opc_q));
        r.displacement = {{8{disp_q[7]}}, disp_q[7:0]};
      end
      IC_ALU_RM, IC_MOV_RM: begin
        r.operation    = (cls == IC_MOV_RM) ? OP_MOV : sel_op(opc_q[5:3]);
        r.form         = FORM_RM_REG;
        r.wide         = opc_q[0];
        r.to_reg       = opc_q[1];
        r.mode         = mrm_q[7:6];
        r.reg_field    = mrm_q[5:3];
        r.rm_field     = mrm_q[2:0];
        r.displacement = disp_q;
      end
      IC_ALU_IMM: begin
        r.operation    = sel_op(mrm_q[5:3]);
        r.form         = FORM_IMM_RM;
        r.wide         = opc_q[0];
        r.mode         = mrm_q[7:6];
        r.rm_field     = mrm_q[2:0];
        r.displacement = disp_q;
        r.immediate    = opc_q[1] ? {{8{imm_q[7]}}, imm_q[7:0]} : imm_q;
      end
      IC_ALU_ACC: begin
        r.operation = sel_op(opc_q[5:3]);
        r.form      = FORM_IMM_AC;
        r.wide      = opc_q[0];
        r.to_reg    = 1'b1;
        r.mode      = MOD_REG;
        r.immediate = imm_q;
      end
      default: begin
        r.operation = OP_MOV;
        r.form      = FORM_IMM_RG;
        r.wide      = opc_q[3];
        r.to_reg    = 1'b1;
        r.mode      = MOD_REG;
        r.reg_field = opc_q[2:0];
        r.immediate = imm_q;
      end
    endcase
    decoded_q.push_back(r);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      $error("field %s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_word();
    result_t want;
    if (decoded_q.size() == 0) begin
      $error("decoded word with none expected: operation %0d length %0d",
             out_ch.operation, out_ch.length);
      n_fail++;
    end else begin
      want = decoded_q.pop_front();
      cmp_field("operation", 16'(want.operation), 16'(out_ch.operation));
      cmp_field("form", 16'(want.form), 16'(out_ch.form));
      cmp_field("jump_kind", 16'(want.jump_kind), 16'(out_ch.jump_kind));
      cmp_field("wide", 16'(want.wide), 16'(out_ch.wide));
      cmp_field("to_reg", 16'(want.to_reg), 16'(out_ch.to_reg));
      cmp_field("mode", 16'(want.mode), 16'(out_ch.mode));
      cmp_field("reg_field", 16'(want.reg_field), 16'(out_ch.reg_field));
      cmp_field("rm_field", 16'(want.rm_field), 16'(out_ch.rm_field));
      cmp_field("displacement", want.displacement, out_ch.displacement);
      cmp_field("immediate", want.immediate, out_ch.immediate);
      cmp_field("length", 16'(want.length), 16'(out_ch.length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_q = WAIT_OPC;
      opc_q  = '0;
      mrm_q  = '0;
      disp_q = '0;
      imm_q  = '0;
      cnt_q  = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.code_byte);
      if (out_ch.valid && out_ch.ready) check_word();
    end
    n_pending <= decoded_q.size();
  end

endmodule

// ----- verif/i8086_subset_instruction_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i8086_subset_instruction_decoder_top_tb - decoder testbench
// Feeds directed and random instruction byte streams with random gaps and
// output stalls; a checker beside the decoder predicts and compares.
// ----------------------------------------------------------------------------
module i8086_subset_instruction_decoder_top_tb;
  import i86dec_pkg::*;

  localparam int CYCLE_LIMIT   = 50000;
  localparam int RANDOM_BYTES  = 330;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_START    = 250;
  localparam int HOLD_CYCLES   = 60;

  logic       clk;
  logic       rst_n;
  logic       quiet;
  int         cyc = 0;
  int         fail_count;
  int         pending;
  logic [7:0] stream_q [$];

  i86dec_in_if  in_ch ();
  i86dec_out_if out_ch ();

  i8086_subset_instruction_decoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  i86dec_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // no idling on either side inside this window
  assign quiet = (cyc >= 350) && (cyc < 500);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("i8086_subset_instruction_decoder_top_tb: done, errors");
      $finish;
    end
  end

  // opcode, mod-reg-rm, displacement bytes as the addressing byte asks, immediate
  task automatic queue_modrm_instr(input logic [7:0] opc, input logic [7:0] mrm,
                                   input logic [15:0] disp, input int n_imm,
                                   input logic [15:0] imm);
    stream_q.push_back(opc);
    stream_q.push_back(mrm);
    if (mrm[7:6] == MOD_D8) begin
      stream_q.push_back(disp[7:0]);
    end else if (mrm[7:6] == MOD_D16 || (mrm[7:6] == MOD_MEM && mrm[2:0] == RM_DIRECT)) begin
      stream_q.push_back(disp[7:0]);
      stream_q.push_back(disp[15:8]);
    end
    if (n_imm >= 1) stream_q.push_back(imm[7:0]);
    if (n_imm == 2) stream_q.push_back(imm[15:8]);
  endtask

  task automatic gen_random_instr();
    logic [2:0]  sels [3];
    logic [7:0]  opc;
    logic [7:0]  mrm;
    logic [15:0] d;
    logic [15:0] v;
    int          pick;
    int          start;
    int          cut;
    sels  = '{SEL_ADD, SEL_SUB, SEL_CMP};
    pick  = $urandom_range(99);
    start = stream_q.size();
    mrm   = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      mrm[7:6] = MOD_MEM;
      mrm[2:0] = RM_DIRECT;
    end
    d = 16'($urandom);
    v = 16'($urandom);
    if (pick < 12) begin
      queue_modrm_instr({6'b100010, 2'($urandom)}, mrm, d, 0, v);
    end else if (pick < 28) begin
      queue_modrm_instr({2'b00, sels[$urandom_range(2)], 1'b0, 2'($urandom)}, mrm, d, 0, v);
    end else if (pick < 40) begin
      opc = {2'b00, sels[$urandom_range(2)], 2'b10, 1'($urandom)};
      stream_q.push_back(opc);
      stream_q.push_back(v[7:0]);
      if (opc[0]) stream_q.push_back(v[15:8]);
    end else if (pick < 58) begin
      opc = {6'b100000, 2'($urandom)};
      if ($urandom_range(9) != 0) mrm[5:3] = sels[$urandom_range(2)];
      if (mrm[5:3] inside {SEL_ADD, SEL_SUB, SEL_CMP}) begin
        queue_modrm_instr(opc, mrm, d, (opc[1:0] == 2'b01) ? 2 : 1, v);
      end else begin
        // bad group op ends the instruction at the addressing byte
        stream_q.push_back(opc);
        stream_q.push_back(mrm);
      end
    end else if (pick < 70) begin
      opc = {4'hB, 4'($urandom)};
      stream_q.push_back(opc);
      stream_q.push_back(v[7:0]);
      if (opc[3]) stream_q.push_back(v[15:8]);
    end else if (pick < 90) begin
      stream_q.push_back(JUMP_TABLE[$urandom_range(JUMP_COUNT - 1)]);
      stream_q.push_back(v[7:0]);
    end else begin
      stream_q.push_back(8'($urandom));
    end
    // now and then cut an instruction short so the next opcode lands mid-decode
    if ($urandom_range(99) < 5 && stream_q.size() - start > 1) begin
      cut = $urandom_range(stream_q.size() - start - 1, 1);
      repeat (cut) void'(stream_q.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stalls plus one long hold-off that backs up the decoder
  initial begin : rx_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc == HOLD_START) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin : tx_side
    int mid_pause;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.code_byte <= 8'h00;

    queue_modrm_instr(8'h89, 8'hD8, 16'h0000, 0, 16'h0000);  // register mode
    queue_modrm_instr(8'h8B, 8'h06, 16'hFFFF, 0, 16'h0000);  // direct address
    queue_modrm_instr(8'h88, 8'h40, 16'h0080, 0, 16'h0000);  // d8, zero-extended
    queue_modrm_instr(8'h8A, 8'hBF, 16'h1234, 0, 16'h0000);
    queue_modrm_instr(8'h8B, 8'h00, 16'h0000, 0, 16'h0000);
    queue_modrm_instr(8'h00, 8'hFF, 16'h0000, 0, 16'h0000);
    queue_modrm_instr(8'h2B, 8'h97, 16'h8000, 0, 16'h0000);
    queue_modrm_instr(8'h39, 8'h7E, 16'h00FF, 0, 16'h0000);
    stream_q.push_back(8'h04); stream_q.push_back(8'hFF);
    stream_q.push_back(8'h2D); stream_q.push_back(8'hFF); stream_q.push_back(8'hFF);
    stream_q.push_back(8'h3C); stream_q.push_back(8'h00);
    queue_modrm_instr(8'h81, 8'hC0, 16'h0000, 2, 16'h1234);  // s=0 w=1: two bytes
    queue_modrm_instr(8'h83, 8'h2E, 16'hABCD, 1, 16'h0080);  // s=1: sign-extended
    queue_modrm_instr(8'h80, 8'h7F, 16'h00FF, 1, 16'h00FF);
    queue_modrm_instr(8'h81, 8'hBE, 16'hFFFF, 2, 16'hFFFF);  // six-byte instruction
    stream_q.push_back(8'h80); stream_q.push_back(8'h08);    // bad group op
    stream_q.push_back(8'h83); stream_q.push_back(8'hF6);
    stream_q.push_back(8'hB0); stream_q.push_back(8'hFF);
    stream_q.push_back(8'hBF); stream_q.push_back(8'hFF); stream_q.push_back(8'hFF);
    stream_q.push_back(8'h74); stream_q.push_back(8'h80);
    stream_q.push_back(8'hE3); stream_q.push_back(8'h7F);
    stream_q.push_back(8'hE2); stream_q.push_back(8'h00);
    stream_q.push_back(8'h0F);                                // unknown opcodes
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h08);
    stream_q.push_back(8'h06);

    mid_pause = stream_q.size() + RANDOM_BYTES / 2;
    while (stream_q.size() < mid_pause + RANDOM_BYTES / 2) gen_random_instr();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == mid_pause) wait_drained();
      send_byte(stream_q[i]);
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("i8086_subset_instruction_decoder_top_tb: done, clean");
    end else begin
      $display("i8086_subset_instruction_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
